### rtl/core/lpl_pkg.sv
// shared constants and types for the look-ahead peak limiter
package lpl_pkg;

  // default structural sizes
  localparam int MaxChannelsDef = 8;
  localparam int MaxWindowDef   = 256;

  // stream payload layout
  localparam int SampleW   = 24;
  localparam int NumFields = 8;
  localparam int FieldSelW = 3;
  localparam int TdataW    = SampleW * NumFields;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // fixed point units
  localparam logic [23:0] GainOne  = 24'd8388608;
  localparam logic [23:0] LevelOne = 24'd1048576;

  // register reset values
  localparam logic [3:0]  ChanCountRst = 4'd2;
  localparam logic [8:0]  WinFramesRst = 9'd240;
  localparam logic [23:0] AttackRst    = 24'd16617027;
  localparam logic [23:0] ReleaseRst   = 24'd16761128;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CHAN_COUNT = 2'd0,
    REG_WIN_FRAMES = 2'd1,
    REG_ATTACK     = 2'd2,
    REG_RELEASE    = 2'd3
  } reg_idx_e;

  // sequencer states
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_INGEST = 13'b0000000000010,
    S_PKWR   = 13'b0000000000100,
    S_SCAN   = 13'b0000000001000,
    S_DIVLD  = 13'b0000000010000,
    S_DIV    = 13'b0000000100000,
    S_CORR   = 13'b0000001000000,
    S_CTGT   = 13'b0000010000000,
    S_MUL    = 13'b0000100000000,
    S_UPD    = 13'b0001000000000,
    S_OMUL   = 13'b0010000000000,
    S_OST    = 13'b0100000000000,
    S_COMMIT = 13'b1000000000000
  } state_e;

endpackage

### rtl/core/lookahead_peak_limiter.sv
// look-ahead peak limiter: sequencer around one divider and one multiplier
// Each request runs through channel ingest, the peak memory write and scan, 24 divider
// steps when the peak exceeds 1.0, target correction and gain smoothing, then, once primed,
// the output multiplies; a request is taken only once the last is through, the next is taken
// while a result waits, and a finished frame holds until the result slot frees
// Reset is asynchronous: control, gains and counters clear, memories are not cleared
module lookahead_peak_limiter #(
  parameter int MAX_CHANNELS = lpl_pkg::MaxChannelsDef,
  parameter int MAX_WINDOW   = lpl_pkg::MaxWindowDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lpl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lpl_pkg::CfgDataW-1:0]  cfg_data_i,
  // input frames
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_0 .. sample_7, 24 bits each, from the lowest bit up
  input  logic [lpl_pkg::TdataW-1:0]    s_axis_tdata,
  // output frames
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_sample_0 .. out_sample_7, 24 bits each, from the lowest bit up
  output logic [lpl_pkg::TdataW-1:0]    m_axis_tdata
);
  import lpl_pkg::*;

  localparam int ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PaW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FlW  = $clog2(MAX_WINDOW + 1);
  localparam int DDep = MAX_WINDOW * MAX_CHANNELS;
  localparam int DaW  = (DDep > 1) ? $clog2(DDep) : 1;

  // reciprocal of 9 scaled by 2^30, exact for numerators below 2^27
  localparam logic [26:0] Div9Recip = 27'd119304648;

  // configuration registers
  logic [3:0]  chan_q;
  logic [8:0]  win_q;
  logic [23:0] att_q, rel_q;

  // sequencer and state
  state_e       state_q, state_d;
  logic [ChW-1:0] ch_q;
  logic [FlW-1:0] fill_q, prime_q, idx_q, wp_q;
  logic [23:0]  peak_q, mx_q, g_q, gain_q, tgt_q;
  logic         pv_q, dv_q;
  logic [ChW-1:0] dch_q;
  logic [4:0]   dcnt_q;
  logic         m_valid_q;

  // payload
  logic signed [23:0] in_q  [MAX_CHANNELS];
  logic signed [23:0] old_q [MAX_CHANNELS];
  logic [23:0]        obuf_q [MAX_CHANNELS];
  logic [TdataW-1:0]  m_data_q;

  // divider datapath
  logic [23:0] rem_q, num_q, quo_q, den_q;
  logic [24:0] dtry;
  logic        dbit;
  logic [23:0] rem_n, quo_n;

  // shared multiplier
  logic signed [27:0] mul_a, mul_b;
  logic signed [55:0] mul_q;

  // memories
  logic signed [23:0] dly_mem [DDep];
  logic [23:0]        pk_mem  [MAX_WINDOW];
  logic signed [23:0] dly_rd_q;
  logic [23:0]        pk_rd_q;

  // effective sizes
  function automatic logic [FlW-1:0] eff_win(input logic [8:0] v);
    if (v == 9'd0) return FlW'(1);
    if (32'(v) > MAX_WINDOW) return FlW'(MAX_WINDOW);
    return FlW'(v);
  endfunction

  logic [3:0]     nch;
  logic [FlW-1:0] weff;
  always_comb begin
    if (chan_q == 4'd0) nch = 4'd1;
    else if (32'(chan_q) > MAX_CHANNELS) nch = 4'(MAX_CHANNELS);
    else nch = chan_q;
    weff = eff_win(win_q);
  end

  logic ch_act, ch_last;
  assign ch_act  = ({1'b0, FieldSelW'(ch_q)} < nch);
  assign ch_last = (32'(ch_q) == MAX_CHANNELS - 1);

  // current channel sample, inactive channels read as silence
  logic signed [23:0] x_cur;
  logic [23:0]        x_mag;
  always_comb begin
    x_cur = ch_act ? in_q[ch_q] : 24'sd0;
    x_mag = x_cur[23] ? 24'(-x_cur) : 24'(x_cur);
  end

  logic [DaW-1:0] dly_addr;
  assign dly_addr = DaW'(DaW'(wp_q) * DaW'(MAX_CHANNELS) + DaW'(ch_q));

  logic [FlW-1:0] wp_inc, fill_inc;
  assign wp_inc   = wp_q + FlW'(1);
  assign fill_inc = (fill_q < weff) ? fill_q + FlW'(1) : weff;

  // one restoring divider step
  always_comb begin
    dtry  = {rem_q, num_q[23]};
    dbit  = (dtry >= {1'b0, den_q});
    rem_n = dbit ? 24'(dtry - {1'b0, den_q}) : dtry[23:0];
    quo_n = {quo_q[22:0], dbit};
  end

  // corrected target numerator 10*g - s + 4
  logic [27:0] corr_num;
  assign corr_num = 28'(28'(g_q) * 28'd10 - 28'(gain_q) + 28'd4);

  // corrected target quotient, numerator times the reciprocal of 9
  logic [23:0] corr_quo;
  assign corr_quo = mul_q[53:30];

  // gain smoothing arithmetic
  logic [24:0] smooth_rnd;
  logic [25:0] up_att, up_rel;
  logic [55:0] mul_rs;
  logic [23:0] out_smp;
  always_comb begin
    smooth_rnd = 25'((mul_q[48:0] + 49'h800000) >> 24);
    up_att     = 26'(tgt_q) + 26'(smooth_rnd);
    if (up_att < 26'(g_q)) up_att = 26'(g_q);
    up_rel     = 26'(tgt_q) - 26'(smooth_rnd);
    mul_rs     = 56'(mul_q + 56'sd4194304);
    out_smp    = mul_rs[46:23];
  end

  // multiplier operand select
  always_comb begin
    mul_a = 28'sd0;
    mul_b = 28'sd0;
    case (state_q)
      S_CORR: begin
        mul_a = $signed(corr_num);
        mul_b = $signed({1'b0, Div9Recip});
      end
      S_MUL: begin
        if (tgt_q < gain_q) begin
          mul_a = $signed({4'b0, att_q});
          mul_b = $signed({4'b0, 24'(gain_q - tgt_q)});
        end else begin
          mul_a = $signed({4'b0, rel_q});
          mul_b = $signed({4'b0, 24'(tgt_q - gain_q)});
        end
      end
      S_OMUL: begin
        mul_a = 28'(old_q[ch_q]);
        mul_b = $signed({4'b0, gain_q});
      end
      default: begin
        mul_a = 28'sd0;
        mul_b = 28'sd0;
      end
    endcase
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_INGEST;
      S_INGEST: if (ch_last) state_d = S_PKWR;
      S_PKWR:   state_d = S_SCAN;
      S_SCAN:   if (idx_q >= fill_q && !pv_q) state_d = S_DIVLD;
      S_DIVLD:  state_d = (mx_q > LevelOne) ? S_DIV : S_CORR;
      S_DIV:    if (dcnt_q == 5'd23) state_d = S_CORR;
      S_CORR:   state_d = (g_q < gain_q) ? S_CTGT : S_MUL;
      S_CTGT:   state_d = S_MUL;
      S_MUL:    state_d = S_UPD;
      S_UPD:    state_d = (prime_q == '0) ? S_OMUL : S_IDLE;
      S_OMUL:   state_d = S_OST;
      S_OST:    state_d = ch_last ? S_COMMIT : S_OMUL;
      S_COMMIT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control registers and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chan_q    <= ChanCountRst;
      win_q     <= WinFramesRst;
      att_q     <= AttackRst;
      rel_q     <= ReleaseRst;
      ch_q      <= '0;
      fill_q    <= '0;
      wp_q      <= '0;
      prime_q   <= eff_win(WinFramesRst);
      idx_q     <= '0;
      gain_q    <= GainOne;
      tgt_q     <= GainOne;
      pv_q      <= 1'b0;
      dv_q      <= 1'b0;
      dch_q     <= '0;
      dcnt_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= (state_q == S_INGEST);
      dch_q   <= ch_q;

      // result slot: set on commit, cleared when taken
      if (state_q == S_COMMIT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;

      // configuration writes, shape changes restart the limiter
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_CHAN_COUNT, REG_WIN_FRAMES: begin
            if (reg_idx_e'(cfg_idx_i) == REG_CHAN_COUNT) begin
              chan_q  <= cfg_data_i[3:0];
              prime_q <= weff;
            end else begin
              win_q   <= cfg_data_i[8:0];
              prime_q <= eff_win(cfg_data_i[8:0]);
            end
            fill_q <= '0;
            wp_q   <= '0;
            gain_q <= GainOne;
            tgt_q  <= GainOne;
          end
          REG_ATTACK:  att_q <= cfg_data_i;
          REG_RELEASE: rel_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: ch_q <= '0;
        S_INGEST: if (!ch_last) ch_q <= ch_q + ChW'(1);
        S_PKWR: begin
          fill_q <= fill_inc;
          wp_q   <= (wp_inc == weff) ? '0 : wp_inc;
          idx_q  <= '0;
          pv_q   <= 1'b0;
        end
        S_SCAN: begin
          if (idx_q < fill_q) begin
            idx_q <= idx_q + FlW'(1);
            pv_q  <= 1'b1;
          end else begin
            pv_q <= 1'b0;
          end
        end
        S_DIVLD: dcnt_q <= '0;
        S_DIV: dcnt_q <= dcnt_q + 5'd1;
        S_CORR: if (g_q >= gain_q) tgt_q <= g_q;
        S_CTGT: if (corr_quo < tgt_q) tgt_q <= corr_quo;
        S_UPD: begin
          gain_q <= (tgt_q < gain_q) ? up_att[23:0] : up_rel[23:0];
          ch_q   <= '0;
          if (prime_q != '0) prime_q <= prime_q - FlW'(1);
        end
        S_OST: if (!ch_last) ch_q <= ch_q + ChW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (dv_q) old_q[dch_q] <= dly_rd_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            in_q[i] <= s_axis_tdata[i*SampleW +: SampleW];
          end
        end
        peak_q <= LevelOne;
      end
      S_INGEST: if (x_mag > peak_q) peak_q <= x_mag;
      S_PKWR: mx_q <= '0;
      S_SCAN: if (pv_q && pk_rd_q > mx_q) mx_q <= pk_rd_q;
      S_DIVLD: begin
        // gain = round(2^43 / max)
        rem_q <= 24'h080000;
        num_q <= 24'(mx_q >> 1);
        den_q <= mx_q;
        quo_q <= '0;
        if (mx_q <= LevelOne) g_q <= GainOne;
      end
      S_DIV: begin
        rem_q <= rem_n;
        num_q <= {num_q[22:0], 1'b0};
        quo_q <= quo_n;
        if (dcnt_q == 5'd23) g_q <= quo_n;
      end
      S_OST: obuf_q[ch_q] <= ch_act ? out_smp : 24'd0;
      S_COMMIT: begin
        if (out_free) begin
          for (int i = 0; i < NumFields; i++) begin
            m_data_q[i*SampleW +: SampleW] <= (i < MAX_CHANNELS) ? obuf_q[i] : 24'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // delay line memory, old sample read out as the new one goes in
  always_ff @(posedge clk_i) begin
    if (state_q == S_INGEST) begin
      dly_rd_q          <= dly_mem[dly_addr];
      dly_mem[dly_addr] <= x_cur;
    end
  end

  // peak window memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_PKWR) pk_mem[PaW'(wp_q)] <= peak_q;
    if (state_q == S_SCAN && idx_q < fill_q) pk_rd_q <= pk_mem[PaW'(idx_q)];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### rtl/core/lpl_checker.sv
// port-level checks for the peak limiter, bound to the top level
module lpl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lpl_pkg::TdataW-1:0]   m_axis_tdata
);
  import lpl_pkg::*;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before taken");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed under stall");

  // one frame in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // no result appears right after a request is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/lookahead_peak_limiter_tb.sv
// self-checking testbench for the look-ahead peak limiter
`timescale 1ns / 1ps

module lookahead_peak_limiter_tb;
  import lpl_pkg::*;

  localparam int          NCH       = 8;
  localparam int          NWIN      = 256;
  localparam int          SETTLE    = 400;
  localparam int          LIMIT     = 2000000;
  localparam int          NUM_ITEMS = 850;
  localparam int          NUM_DIR   = 14;
  localparam int          NUM_TYPED = 4;
  localparam logic [23:0] CoefMax   = 24'hFFFFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TdataW-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TdataW-1:0]  m_axis_tdata;

  lookahead_peak_limiter i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [3:0]          lim_chan;
  logic [8:0]          lim_win;
  logic [23:0]         lim_att;
  logic [23:0]         lim_rel;
  logic signed [23:0]  delay_mem [NWIN*NCH];
  longint unsigned     peak_mem [NWIN];
  int unsigned         fill_cnt;
  int unsigned         wr_ptr;
  longint unsigned     gain_now;
  longint unsigned     gain_target;
  int unsigned         prime_left;

  logic [TdataW-1:0]   frame_q [$];
  int                  mismatches = 0;
  bit                  no_idle = 1'b0;
  int unsigned         cycles = 0;

  function automatic int unsigned act_chan();
    if (lim_chan == 0) return 1;
    if (lim_chan > NCH) return NCH;
    return lim_chan;
  endfunction

  function automatic int unsigned act_win();
    if (lim_win == 0) return 1;
    if (lim_win > NWIN) return NWIN;
    return lim_win;
  endfunction

  function automatic void restart_shape();
    fill_cnt    = 0;
    wr_ptr      = 0;
    gain_now    = GainOne;
    gain_target = GainOne;
    prime_left  = act_win();
  endfunction

  function automatic void shadow_cfg(reg_idx_e idx, logic [23:0] val);
    case (idx)
      REG_CHAN_COUNT: begin
        lim_chan = val[3:0];
        restart_shape();
      end
      REG_WIN_FRAMES: begin
        lim_win = val[8:0];
        restart_shape();
      end
      REG_ATTACK:  lim_att = val;
      REG_RELEASE: lim_rel = val;
      default: ;
    endcase
  endfunction

  // gain follower: raw 1/max, corrected target, attack or release smoothing
  function automatic void follow_gain(longint unsigned mx);
    longint unsigned g;
    longint unsigned s;
    longint unsigned c;
    g = GainOne;
    s = gain_now;
    if (mx > LevelOne) g = ((64'd1 << 43) + mx / 2) / mx;
    if (g < s) begin
      c = (10 * g - s + 4) / 9;
      if (c < gain_target) gain_target = c;
    end else begin
      gain_target = g;
    end
    if (gain_target < s) begin
      s = gain_target + ((lim_att * (s - gain_target) + (64'd1 << 23)) >> 24);
      if (s < g) s = g;
    end else begin
      s = gain_target - ((lim_rel * (gain_target - s) + (64'd1 << 23)) >> 24);
    end
    gain_now = s;
  endfunction

  // one frame through the limiter; returns 1 when a delayed frame comes out
  function automatic bit limit_frame(logic [TdataW-1:0] din, output logic [TdataW-1:0] dout);
    int unsigned        nch;
    int unsigned        w;
    int unsigned        p;
    longint unsigned    peak;
    longint unsigned    mx;
    longint signed      x;
    longint unsigned    m;
    longint signed      prod;
    logic signed [23:0] frame [NCH];
    bit                 emit;
    nch  = act_chan();
    w    = act_win();
    p    = wr_ptr % w;
    peak = LevelOne;
    mx   = 0;
    dout = '0;
    for (int i = 0; i < NCH; i++) begin
      x = (i < nch) ? longint'($signed(din[i*SampleW +: SampleW])) : 0;
      m = (x < 0) ? -x : x;
      frame[i] = x[23:0];
      if (m > peak) peak = m;
    end
    peak_mem[p] = peak;
    if (fill_cnt < w) fill_cnt++;
    if (fill_cnt > w) fill_cnt = w;
    for (int i = 0; i < fill_cnt; i++)
      if (peak_mem[i] > mx) mx = peak_mem[i];
    follow_gain(mx);
    emit = (prime_left == 0);
    if (!emit) prime_left--;
    for (int i = 0; i < NCH; i++) begin
      if (emit && i < nch) begin
        prod = longint'(delay_mem[p*NCH + i]) * longint'(gain_now);
        prod = (prod + (64'sd1 <<< 22)) >>> 23;
        dout[i*SampleW +: SampleW] = prod[23:0];
      end
      delay_mem[p*NCH + i] = frame[i];
    end
    wr_ptr = (p + 1) % w;
    return emit;
  endfunction

  // one register write, only while idle
  task automatic write_reg(reg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    shadow_cfg(idx, val);
  endtask

  task automatic drain_results();
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // send one frame; typed expectation overrides the predicted one
  task automatic send_frame(logic [TdataW-1:0] data, bit typed, bit typed_emit,
                            logic [TdataW-1:0] typed_out);
    logic [TdataW-1:0] pred;
    bit                emit;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 13) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
    emit = limit_frame(data, pred);
    if (typed) begin
      if (typed_emit) frame_q.push_back(typed_out);
      if (typed_emit != emit || (emit && typed_out != pred)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed row: expected %0d %h, model %0d %h", typed_emit, typed_out,
                   emit, pred);
      end
    end else if (emit) begin
      frame_q.push_back(pred);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sd8388607;
      1: return -24'sd8388608;
      2: return 24'($urandom_range(2097152) - 1048576);
      default: return 24'($urandom());
    endcase
  endfunction

  // receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 13);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    logic [TdataW-1:0] exp_frame;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        exp_frame = frame_q[0];
        frame_q.delete(0);
        for (int i = 0; i < NCH; i++) begin
          if (m_axis_tdata[i*SampleW +: SampleW] != exp_frame[i*SampleW +: SampleW]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_sample_%0d: expected %h got %h", i,
                       exp_frame[i*SampleW +: SampleW], m_axis_tdata[i*SampleW +: SampleW]);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("lookahead_peak_limiter regression: fail");
      $finish;
    end
  end

  typedef struct {
    logic [TdataW-1:0] data;
    bit                typed;
    bit                emit;
    logic [TdataW-1:0] out;
  } dir_row_t;

  dir_row_t          dir_tab [NUM_DIR];
  logic [TdataW-1:0] small_frame [NUM_TYPED];

  initial begin
    logic [TdataW-1:0] d;
    logic [3:0]        ch;
    logic [8:0]        wn;
    logic [23:0]       att;
    logic [23:0]       rel;
    int                sent;
    int                n;
    int                phase;

    // reset state of the predictor
    lim_chan = ChanCountRst;
    lim_win  = WinFramesRst;
    lim_att  = AttackRst;
    lim_rel  = ReleaseRst;
    restart_shape();
    foreach (delay_mem[i]) delay_mem[i] = '0;
    foreach (peak_mem[i]) peak_mem[i] = 0;

    // directed frames: the first ones stay within 1.0, so gain stays one
    for (int r = 0; r < NUM_TYPED; r++) begin
      for (int i = 0; i < NCH; i++)
        small_frame[r][i*SampleW +: SampleW] = 24'((r * 8 + i) * 60000 - 1048576);
    end
    small_frame[0][0 +: SampleW] = LevelOne;
    for (int r = 0; r < NUM_DIR; r++) begin
      dir_tab[r].typed = (r < NUM_TYPED);
      dir_tab[r].emit  = (r > 0);
      dir_tab[r].out   = (r > 0 && r < NUM_TYPED) ? small_frame[r-1] : '0;
      if (r < NUM_TYPED) dir_tab[r].data = small_frame[r];
      else begin
        for (int i = 0; i < NCH; i++) begin
          case ((r + i) % 4)
            0: d[i*SampleW +: SampleW] = 24'sd8388607;
            1: d[i*SampleW +: SampleW] = -24'sd8388608;
            2: d[i*SampleW +: SampleW] = '0;
            default: d[i*SampleW +: SampleW] = -24'sd1048577;
          endcase
        end
        if (r >= 10) d = '0;  // silent frames flush the delay line
        dir_tab[r].data = d;
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(REG_CHAN_COUNT, 24'd8);
    write_reg(REG_WIN_FRAMES, 24'd1);
    foreach (dir_tab[r])
      send_frame(dir_tab[r].data, dir_tab[r].typed, dir_tab[r].emit, dir_tab[r].out);

    // random phases, each with its own shape and coefficients
    sent  = 0;
    phase = 0;
    while (sent < NUM_ITEMS) begin
      drain_results();
      case (phase)
        0: begin ch = 4'd8;  wn = 9'd256; att = '0;      rel = CoefMax; end
        1: begin ch = 4'd0;  wn = 9'd0;   att = CoefMax; rel = '0;      end
        2: begin ch = 4'd15; wn = 9'd1;   att = CoefMax; rel = CoefMax; end
        3: begin ch = 4'd1;  wn = 9'd511; att = '0;      rel = '0;      end
        default: begin
          ch  = 4'($urandom_range(15));
          wn  = 9'($urandom_range(12));
          att = ($urandom_range(3) == 0) ? AttackRst : 24'($urandom());
          rel = ($urandom_range(3) == 0) ? ReleaseRst : 24'($urandom());
        end
      endcase
      no_idle = (phase == 5);
      write_reg(REG_ATTACK, att);
      write_reg(REG_RELEASE, rel);
      write_reg(REG_CHAN_COUNT, 24'(ch));
      write_reg(REG_WIN_FRAMES, 24'(wn));
      n = act_win() + $urandom_range(20, 50);
      for (int k = 0; k < n; k++) begin
        // each sample lies within 1.0 with chance one in four, else comes from rand_sample
        for (int i = 0; i < NCH; i++)
          d[i*SampleW +: SampleW] = ($urandom_range(3) == 0) ?
                                    24'($urandom_range(2097152) - 1048576) : rand_sample();
        send_frame(d, 1'b0, 1'b0, '0);
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;

    drain_results();
    if (frame_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("lookahead_peak_limiter regression: pass");
    end else begin
      $display("lookahead_peak_limiter regression: fail");
    end
    $finish;
  end

endmodule
